FILE: sv/twt_pkg.sv
package twt_pkg;

    typedef enum logic [1:0] {
        PH_INIT,
        PH_WORD,
        PH_SPACE
    } t_phase;

    typedef enum logic [1:0] {
        TK_CHUNK = 2'd0,
        TK_SPACE = 2'd1,
        TK_PARA  = 2'd2,
        TK_END   = 2'd3
    } t_tok_kind;

    typedef enum logic [2:0] {
        CFG_BREAK_HYPHENS  = 3'd0,
        CFG_REPLACE_SPACE  = 3'd1,
        CFG_COLLAPSE_SPACE = 3'd2,
        CFG_TAB_LITERAL    = 3'd3,
        CFG_TAB_WIDTH      = 3'd4
    } t_cfg_idx;

    localparam int unsigned TAB_MAX   = 8;
    localparam int unsigned ROOM_MAX  = 8;
    localparam int unsigned TW_LIM    = (TAB_MAX < ROOM_MAX) ? TAB_MAX : ROOM_MAX;
    localparam int unsigned CNT_W     = 4;

    localparam logic [7:0] CH_HYPHEN  = 8'h2D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // pending results of one input, sent in field order
    typedef struct packed {
        logic             pre;
        logic             nl;
        logic [7:0]       nl_byte;
        logic             spm;
        logic [CNT_W-1:0] rep_cnt;
        t_tok_kind        rep_kind;
        logic [7:0]       rep_byte;
        logic             post;
        t_tok_kind        post_kind;
    } t_plan;

endpackage

FILE: sv/twt_in_if.sv
interface twt_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_byte;

    modport source (output valid, output kind, output text_byte, input ready);
    modport sink (input valid, input kind, input text_byte, output ready);
endinterface

FILE: sv/twt_out_if.sv
interface twt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] token_kind;
    logic       is_marker;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (
        output valid, output token_kind, output is_marker, output out_byte,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input is_marker, input out_byte,
        input last_of_run, output ready
    );
endinterface

FILE: sv/text_wrap_tokenizer_core.sv
// Streaming text tokenizer: one byte (or end of input) per transaction in, a stream of
// token characters and closing markers out. Each accepted byte is decoded into a
// pending-result register, which then delivers one result per cycle while o_tok.ready
// is high; an input causes 0 to 9 results (the largest for an expanded tab), and the
// next input is taken in the same cycle as the previous one's last result, so plain
// text flows at one byte per cycle when the output does not stall. Inputs causing no
// result (a first newline) leave the register empty. The user must write configuration
// through the plain write port only while the block is idle; nothing enforces it.
module text_wrap_tokenizer_core
    import twt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_wdata,
    twt_in_if.sink      i_text,
    twt_out_if.source   o_tok
);

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    logic             r_break_hyph;
    logic             r_replace;
    logic             r_collapse;
    logic             r_tab_lit;
    logic [3:0]       r_tab_width;

    t_phase           r_phase,       n_phase;
    logic             r_chunk_open,  n_chunk_open;
    logic             r_space_open,  n_space_open;
    logic             r_nl_held,     n_nl_held;
    logic             r_prev_letter, n_prev_letter;
    t_plan            r_plan,        n_plan;

    t_plan            plan_new;
    t_plan            plan_adv;
    logic             so;
    logic [CNT_W-1:0] tw;
    logic [CNT_W-1:0] cnt_raw;
    logic [4:0]       total;
    logic             last;
    logic             in_fire;
    logic             out_fire;
    logic [7:0]       c;

    assign c        = i_text.text_byte;
    assign tw       = (r_tab_width > CNT_W'(TW_LIM)) ? CNT_W'(TW_LIM) : r_tab_width;
    assign total    = 5'(r_plan.pre) + 5'(r_plan.nl) + 5'(r_plan.spm)
                    + 5'(r_plan.rep_cnt) + 5'(r_plan.post);
    assign last     = (total == 5'd1);
    assign o_tok.valid = (total != 5'd0);
    assign out_fire = o_tok.valid && o_tok.ready;
    assign i_text.ready = (total == 5'd0) || (out_fire && last);
    assign in_fire  = i_text.valid && i_text.ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_hyph <= 1'b0;
            r_replace    <= 1'b0;
            r_collapse   <= 1'b0;
            r_tab_lit    <= 1'b1;
            r_tab_width  <= 4'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BREAK_HYPHENS:  r_break_hyph <= i_cfg_wdata[0];
                CFG_REPLACE_SPACE:  r_replace    <= i_cfg_wdata[0];
                CFG_COLLAPSE_SPACE: r_collapse   <= i_cfg_wdata[0];
                CFG_TAB_LITERAL:    r_tab_lit    <= i_cfg_wdata[0];
                CFG_TAB_WIDTH:      r_tab_width  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // decode of one input into state update and pending results
    always_comb begin
        n_phase       = r_phase;
        n_chunk_open  = r_chunk_open;
        n_space_open  = r_space_open;
        n_nl_held     = r_nl_held;
        n_prev_letter = r_prev_letter;
        so            = r_space_open;
        cnt_raw       = '0;
        plan_new           = '0;
        plan_new.rep_kind  = TK_CHUNK;
        plan_new.post_kind = TK_END;
        plan_new.nl_byte   = (r_collapse || r_replace) ? CH_SPACE : CH_NEWLINE;
        if (i_text.kind) begin
            plan_new.pre = (r_phase == PH_WORD) && r_chunk_open;
            if (r_phase == PH_SPACE) begin
                plan_new.nl  = r_nl_held && (!r_collapse || !r_space_open);
                plan_new.spm = r_space_open || r_nl_held;
            end
            plan_new.post      = 1'b1;
            plan_new.post_kind = TK_END;
            n_phase      = PH_INIT;
            n_chunk_open = 1'b0;
            n_space_open = 1'b0;
            n_nl_held    = 1'b0;
        end else if (is_ws(c)) begin
            plan_new.pre = (r_phase == PH_WORD) && r_chunk_open;
            n_chunk_open = 1'b0;
            n_phase      = PH_SPACE;
            if (c == CH_NEWLINE) begin
                if (r_nl_held) begin
                    n_nl_held          = 1'b0;
                    plan_new.spm       = r_space_open;
                    n_space_open       = 1'b0;
                    plan_new.post      = 1'b1;
                    plan_new.post_kind = TK_PARA;
                end else begin
                    n_nl_held = 1'b1;
                end
            end else begin
                if (r_nl_held) begin
                    plan_new.nl = !r_collapse || !r_space_open;
                    so          = 1'b1;
                end
                n_nl_held = 1'b0;
                if ((c == CH_TAB) && !r_tab_lit) begin
                    cnt_raw           = tw;
                    plan_new.rep_byte = CH_SPACE;
                end else begin
                    cnt_raw           = CNT_W'(1);
                    plan_new.rep_byte = (r_collapse || r_replace) ? CH_SPACE : c;
                end
                if (r_collapse) begin
                    plan_new.rep_cnt = ((cnt_raw != '0) && !so) ? CNT_W'(1) : '0;
                end else begin
                    plan_new.rep_cnt = cnt_raw;
                end
                plan_new.rep_kind = TK_SPACE;
                n_space_open      = so || (cnt_raw != '0);
            end
        end else begin
            if (r_phase == PH_SPACE) begin
                plan_new.nl  = r_nl_held && (!r_collapse || !r_space_open);
                plan_new.spm = r_space_open || r_nl_held;
            end
            n_space_open      = 1'b0;
            n_nl_held         = 1'b0;
            n_phase           = PH_WORD;
            plan_new.rep_cnt  = CNT_W'(1);
            plan_new.rep_byte = c;
            plan_new.rep_kind = TK_CHUNK;
            if (r_break_hyph && (c == CH_HYPHEN) && r_chunk_open && r_prev_letter) begin
                plan_new.post      = 1'b1;
                plan_new.post_kind = TK_CHUNK;
                n_chunk_open       = 1'b0;
            end else begin
                n_chunk_open = 1'b1;
            end
            n_prev_letter = is_letter(c);
        end
    end

    // result sequencing from the pending-result register
    always_comb begin
        plan_adv          = r_plan;
        o_tok.last_of_run = last;
        o_tok.is_marker   = 1'b1;
        o_tok.out_byte    = 8'h00;
        o_tok.token_kind  = TK_END;
        priority if (r_plan.pre) begin
            o_tok.token_kind = TK_CHUNK;
            plan_adv.pre     = 1'b0;
        end else if (r_plan.nl) begin
            o_tok.token_kind = TK_SPACE;
            o_tok.is_marker  = 1'b0;
            o_tok.out_byte   = r_plan.nl_byte;
            plan_adv.nl      = 1'b0;
        end else if (r_plan.spm) begin
            o_tok.token_kind = TK_SPACE;
            plan_adv.spm     = 1'b0;
        end else if (r_plan.rep_cnt != '0) begin
            o_tok.token_kind = r_plan.rep_kind;
            o_tok.is_marker  = 1'b0;
            o_tok.out_byte   = r_plan.rep_byte;
            plan_adv.rep_cnt = r_plan.rep_cnt - CNT_W'(1);
        end else begin
            o_tok.token_kind = r_plan.post_kind;
            plan_adv.post    = 1'b0;
        end
        if (in_fire) begin
            n_plan = plan_new;
        end else if (out_fire) begin
            n_plan = plan_adv;
        end else begin
            n_plan = r_plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_INIT;
            r_chunk_open  <= 1'b0;
            r_space_open  <= 1'b0;
            r_nl_held     <= 1'b0;
            r_prev_letter <= 1'b0;
            r_plan        <= '0;
        end else begin
            r_plan <= n_plan;
            if (in_fire) begin
                r_phase       <= n_phase;
                r_chunk_open  <= n_chunk_open;
                r_space_open  <= n_space_open;
                r_nl_held     <= n_nl_held;
                r_prev_letter <= n_prev_letter;
            end
        end
    end

`ifndef SYNTHESIS
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_text.ready |-> (!o_tok.valid || (o_tok.ready && o_tok.last_of_run)))
        else $error("input taken while earlier results pending");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_text.valid && i_text.ready && i_text.kind)
            |=> (r_phase == PH_INIT && !r_nl_held && !r_space_open && !r_chunk_open))
        else $error("end of input left a token open");

    a_held_in_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nl_held || r_space_open) |-> (r_phase == PH_SPACE))
        else $error("white-space state outside white-space phase");

    a_chunk_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunk_open |-> (r_phase == PH_WORD))
        else $error("chunk open outside word phase");
`endif

endmodule
